/* src/lphm_pkg.sv */
// Shared constants, types and helper functions for the linear probe hash map.
package lphm_pkg;

    localparam int SLOTS   = 1024;              // table depth, a power of two
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 32;
    localparam int OCC_W   = 11;
    localparam int LR_W    = 5;
    localparam int ENTRY_W = KEY_W + VAL_W;     // key in the low bits, value above
    localparam int IN_W    = KEY_W + VAL_W;
    localparam int OUT_RAW_W = VAL_W + STAT_W + CNT_W + OCC_W;
    localparam int OUT_W   = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int LOAD_W  = OCC_W + LR_W;

    localparam logic [OCC_W-1:0] OCC_MAX   = '1;
    localparam logic [VAL_W-1:0] TOMBSTONE = 32'h8000_0000;

    localparam logic [63:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_KEYZERO = 2'd2;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } hash_rsp_t;

    // Either signed zero marks an empty or deleted value word.
    function automatic logic is_zero_word(input logic [VAL_W-1:0] w);
        return (w[VAL_W-2:0] == '0);
    endfunction

endpackage

/* src/lphm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/lphm_hash.sv */
// Iterative key mixer: one shared 32x32 multiplier builds both 64-bit products.
module lphm_hash (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lphm_pkg::KEY_W-1:0]     key,
    output lphm_pkg::hash_rsp_t            rsp
);

    logic                          busy_reg, busy_next;
    logic                          phase_reg, phase_next;
    logic [2:0]                    sub_reg, sub_next;
    logic                          done_reg, done_next;
    logic [lphm_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [63:0]                   h_reg, h_next;
    logic [63:0]                   acc_reg, acc_next;
    logic [63:0]                   prod_reg, prod_next;

    logic [63:0] mul_const;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_out;
    logic [63:0] acc_sum;
    logic [63:0] mix_mid;
    logic [63:0] mix_end;

    // Each 64x64 product modulo 2^64 is lo*lo plus the two cross terms shifted up.
    assign mul_const = phase_reg ? lphm_pkg::MIX_C2 : lphm_pkg::MIX_C1;
    assign op_a      = (sub_reg == 3'd2) ? h_reg[63:32] : h_reg[31:0];
    assign op_b      = (sub_reg == 3'd1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_out   = 64'(op_a) * 64'(op_b);
    assign acc_sum   = acc_reg + {prod_reg[31:0], 32'd0};
    assign mix_mid   = acc_reg ^ (acc_reg >> lphm_pkg::MIX_SH2);
    assign mix_end   = acc_reg ^ (acc_reg >> lphm_pkg::MIX_SH3);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        done_next  = 1'b0;
        slot_next  = slot_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            h_next     = key ^ (key >> lphm_pkg::MIX_SH1);
            busy_next  = 1'b1;
            phase_next = 1'b0;
            sub_next   = 3'd0;
        end
        else if (busy_reg)
        begin
            prod_next = mul_out;
            sub_next  = sub_reg + 3'd1;
            case (sub_reg)
                3'd0:
                begin
                end
                3'd1:
                begin
                    acc_next = prod_reg;
                end
                3'd2, 3'd3:
                begin
                    acc_next = acc_sum;
                end
                3'd4:
                begin
                    sub_next = 3'd0;
                    if (!phase_reg)
                    begin
                        h_next     = mix_mid;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        slot_next = mix_end[lphm_pkg::SLOT_W-1:0];
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    sub_next  = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            sub_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        h_reg    <= h_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.slot = slot_reg;

endmodule

/* src/linear_probe_hash_map_top.sv */
// Top level of the linear probe hash map: sequencer, counters and table storage.
//
// Usage: each item on the s_ channel carries an operation in s_tuser (insert, get,
// erase, or no-op) and a 64-bit key plus a 32-bit value word in s_tdata. Every
// accepted item produces exactly one result item on the m_ channel with the read
// value, a status code, the live entry count and the used slot count.
// The load ratio register is written through cfg_valid/cfg_ready/cfg_data, which
// is always ready; write it only while no item is in flight.
//
// Timing: the block holds one item at a time; s_tready is high only in idle. No-ops,
// key-zero items and inserts refused by the load check go straight to the result
// register. Other items pass through the key mixer (ten steps of the shared 32x32
// multiplier plus its result register), then probe one slot at a time on the table
// RAM read port, and then load the result register.
//
// Reset: after rst_n releases, a clearing pass writes zero to all 1024 table
// entries, one per cycle; s_tready stays low until the pass is over.
// Stall: the result waits in the output register; the block takes the next item
// meanwhile, and holds its new result until the previous one has been taken.
module linear_probe_hash_map_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel: cfg_data is load_ratio.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lphm_pkg::LR_W-1:0]      cfg_data,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lphm_pkg::IN_W-1:0]      s_tdata,  // key [63:0], value [95:64]
    input  logic [lphm_pkg::FUNC_W-1:0]    s_tuser,  // func [1:0]
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value [31:0], status [33:32], live_count [65:34], used_slots [76:66],
    // zero [79:77]
    output logic [lphm_pkg::OUT_W-1:0]     m_tdata
);

    // Sequencer state codes.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    localparam logic [lphm_pkg::LOAD_W:0] SLOTS_CMP = (lphm_pkg::LOAD_W + 1)'(lphm_pkg::SLOTS);

    logic [2:0]                          state_reg, state_next;
    logic [lphm_pkg::SLOT_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [lphm_pkg::FUNC_W-1:0]         func_reg, func_next;
    logic [lphm_pkg::KEY_W-1:0]          key_reg, key_next;
    logic [lphm_pkg::VAL_W-1:0]          val_reg, val_next;
    logic [lphm_pkg::SLOT_W-1:0]         pos_reg, pos_next;
    logic [lphm_pkg::SLOT_W-1:0]         probes_reg, probes_next;
    logic [lphm_pkg::VAL_W-1:0]          res_rd_reg, res_rd_next;
    logic [lphm_pkg::STAT_W-1:0]         res_stat_reg, res_stat_next;
    logic [lphm_pkg::CNT_W-1:0]          entry_reg, entry_next;
    logic [lphm_pkg::OCC_W-1:0]          occ_reg, occ_next;
    logic [lphm_pkg::LR_W-1:0]           lr_reg, lr_next;
    logic                                out_valid_reg, out_valid_next;
    logic [lphm_pkg::OUT_W-1:0]          out_data_reg, out_data_next;

    logic                                accept;
    logic [lphm_pkg::FUNC_W-1:0]         in_func;
    logic [lphm_pkg::KEY_W-1:0]          in_key;
    logic [lphm_pkg::VAL_W-1:0]          in_val;
    logic [lphm_pkg::LOAD_W-1:0]         load_prod;
    logic                                load_full;

    logic                                hash_start;
    lphm_pkg::hash_rsp_t                 hash_rsp;

    logic                                ram_we;
    logic [lphm_pkg::SLOT_W-1:0]         ram_waddr;
    logic [lphm_pkg::ENTRY_W-1:0]        ram_wdata;
    logic [lphm_pkg::ENTRY_W-1:0]        ram_rdata;
    logic [lphm_pkg::KEY_W-1:0]          rd_key;
    logic [lphm_pkg::VAL_W-1:0]          rd_val;
    logic                                slot_hit;

    assign in_func  = s_tuser;
    assign in_key   = s_tdata[lphm_pkg::KEY_W-1:0];
    assign in_val   = s_tdata[lphm_pkg::IN_W-1:lphm_pkg::KEY_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Insert is refused once used_slots * load_ratio exceeds the slot count.
    assign load_prod = lphm_pkg::LOAD_W'(occ_reg) * lphm_pkg::LOAD_W'(lr_reg);
    assign load_full = ({1'b0, load_prod} > SLOTS_CMP);

    // Table entry: key in the low bits, value word above it.
    assign rd_key   = ram_rdata[lphm_pkg::KEY_W-1:0];
    assign rd_val   = ram_rdata[lphm_pkg::ENTRY_W-1:lphm_pkg::KEY_W];
    assign slot_hit = (rd_key == '0) || (rd_key == key_reg);

    lphm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (in_key),
        .rsp   (hash_rsp)
    );

    // The read address follows the next probe position, so the entry for
    // pos_reg is on ram_rdata in every probe cycle.
    lphm_ram #(
        .WIDTH (lphm_pkg::ENTRY_W),
        .DEPTH (lphm_pkg::SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        probes_next    = probes_reg;
        res_rd_next    = res_rd_reg;
        res_stat_next  = res_stat_reg;
        entry_next     = entry_reg;
        occ_next       = occ_reg;
        lr_next        = lr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        hash_start     = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = {val_reg, key_reg};

        if (cfg_valid && cfg_ready)
        begin
            lr_next = cfg_data;
        end

        // The current result leaves; a new one may replace it below.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = in_func;
                    key_next      = in_key;
                    val_next      = in_val;
                    res_rd_next   = '0;
                    res_stat_next = lphm_pkg::STAT_OK;
                    if (in_func == lphm_pkg::FN_NOP)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (in_key == '0)
                    begin
                        res_stat_next = lphm_pkg::STAT_KEYZERO;
                        state_next    = ST_RESP;
                    end
                    else if ((in_func == lphm_pkg::FN_INSERT) && load_full)
                    begin
                        res_stat_next = lphm_pkg::STAT_FULL;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_rsp.done)
                begin
                    pos_next    = hash_rsp.slot;
                    probes_next = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (slot_hit)
                begin
                    state_next = ST_RESP;
                    case (func_reg)
                        lphm_pkg::FN_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {val_reg, key_reg};
                            entry_next = entry_reg + 1'b1;
                            if (lphm_pkg::is_zero_word(rd_val) && (occ_reg != lphm_pkg::OCC_MAX))
                            begin
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        lphm_pkg::FN_GET:
                        begin
                            if (!lphm_pkg::is_zero_word(rd_val))
                            begin
                                res_rd_next = rd_val;
                            end
                        end
                        lphm_pkg::FN_ERASE:
                        begin
                            // An erased key stays in place; only its value is marked.
                            if (rd_key != '0)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = {lphm_pkg::TOMBSTONE, key_reg};
                                entry_next = entry_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (probes_reg == '1)
                begin
                    // Every slot was probed without a match or an empty key.
                    if (func_reg == lphm_pkg::FN_INSERT)
                    begin
                        res_stat_next = lphm_pkg::STAT_FULL;
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    pos_next    = pos_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = lphm_pkg::OUT_W'({occ_reg, entry_reg,
                                                       res_stat_reg, res_rd_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            probes_reg    <= '0;
            entry_reg     <= '0;
            occ_reg       <= '0;
            lr_reg        <= lphm_pkg::LR_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            probes_reg    <= probes_next;
            entry_reg     <= entry_next;
            occ_reg       <= occ_next;
            lr_reg        <= lr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        res_rd_reg   <= res_rd_next;
        res_stat_reg <= res_stat_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The table is written only by the clearing pass or at the end of a probe.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_CHECK)))
        else $error("table write outside clear or probe");

    // The used slot count never goes down.
    a_occ_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (occ_reg >= $past(occ_reg)))
        else $error("used slot count decreased");

    // The mixer only finishes while the sequencer is waiting for it.
    a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
        hash_rsp.done |-> (state_reg == ST_HASH))
        else $error("mixer result arrived outside hash wait");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && (state_reg == ST_RESP)) |=> (state_reg == ST_RESP))
        else $error("result register reloaded while stalled");

endmodule
